// ----- sv/timer_deadline_queue_unit_assert.svh -----
// Assertion macros for the checker in tdq_mon.sv.
`ifndef TIMER_DEADLINE_QUEUE_UNIT_ASSERT_SVH
`define TIMER_DEADLINE_QUEUE_UNIT_ASSERT_SVH

// Checked on every clock edge outside reset.
`define TDQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TDQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- sv/tdq_pkg.sv -----
`timescale 1ns / 1ps

package tdq_pkg;

    localparam int TIMER_SLOTS     = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int SLOT_W          = $clog2(TIMER_SLOTS);
    localparam int FIRE_W          = $clog2(MAX_RESULTS);
    localparam int CNT_W           = $clog2(MAX_RESULTS + 1);
    localparam int TIME_W          = 64;
    localparam int PERIOD_W        = 32;
    localparam int MIN_DELAY_W     = 20;
    localparam logic [MIN_DELAY_W-1:0] MIN_DELAY_RESET = MIN_DELAY_W'(100);

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_CANCEL = 2'd1,
        ACT_TICK   = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_CANCEL = 2'd1,
        KIND_TICK   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_SLOT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ALU_GE      = 2'd0,
        ALU_LT      = 2'd1,
        ALU_SUB_SAT = 2'd2,
        ALU_ADD_SAT = 2'd3
    } t_alu_op;

    // write request from the sequencer to the slot table
    typedef struct packed {
        logic                add_en;
        logic                cancel_en;
        logic                free_en;
        logic                dl_en;
        logic [SLOT_W-1:0]   idx;
        logic [TIME_W-1:0]   deadline;
        logic [PERIOD_W-1:0] period;
    } t_tbl_wr;

endpackage

// ----- sv/timer_deadline_queue_unit.sv -----
`timescale 1ns / 1ps

// Channel     | Direction | Handshake                 | Payload
// command     | in        | start / busy              | i_action i_slot i_deadline i_period i_now
// result      | out       | o_result_strobe           | o_kind o_status o_result_slot o_expired
//             |           |                           | o_arm_valid o_arm_delay o_last
// min_delay   | in        | i_cfg_valid / o_cfg_ready | i_cfg_data
//
// One slot is visited per cycle through a single table read port and one shared
// 64-bit adder/comparator. An add scans every slot, then works out the delay when
// the wake-up re-arms; a cancel marks its slot directly. A tick runs a cancelled
// clear, repeated ordered picks of the earliest due timer (up to MAX_RESULTS),
// re-arm, earliest search and the delay (only while a slot remains valid), then
// gives one result per fired timer, or a single result when none fired.
// Synchronous active-low reset clears the slot table valid bits; min_delay returns to 100.
// Results of a tick come on consecutive cycles; the receiver cannot stall them.
module timer_deadline_queue_unit import tdq_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_action,
    input  logic [3:0]             i_slot,
    input  logic [TIME_W-1:0]      i_deadline,
    input  logic [PERIOD_W-1:0]    i_period,
    input  logic [TIME_W-1:0]      i_now,
    output logic                   o_result_strobe,
    output logic [1:0]             o_kind,
    output logic [1:0]             o_status,
    output logic [3:0]             o_result_slot,
    output logic                   o_expired,
    output logic                   o_arm_valid,
    output logic [TIME_W-1:0]      o_arm_delay,
    output logic                   o_last,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [MIN_DELAY_W-1:0] i_cfg_data
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_ADD_SCAN = 10'b0000000010,
        S_CAN      = 10'b0000000100,
        S_CLR      = 10'b0000001000,
        S_PICK     = 10'b0000010000,
        S_UPD      = 10'b0000100000,
        S_BEST     = 10'b0001000000,
        S_DSUB     = 10'b0010000000,
        S_DMIN     = 10'b0100000000,
        S_EMIT     = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    // latched command
    logic [1:0]             r_action;
    logic [3:0]             r_slot;
    logic [TIME_W-1:0]      r_deadline;
    logic [PERIOD_W-1:0]    r_period;
    logic [TIME_W-1:0]      r_now;

    logic [MIN_DELAY_W-1:0] r_min_delay;
    logic [SLOT_W-1:0]      r_idx;

    logic                   r_free_found;
    logic [SLOT_W-1:0]      r_free_idx;
    logic                   r_earliest;
    t_status                r_status;

    logic [TIMER_SLOTS-1:0] r_due;
    logic [TIMER_SLOTS-1:0] r_handled;
    logic                   r_pick_found;
    logic [SLOT_W-1:0]      r_pick_idx;
    logic [TIME_W-1:0]      r_pick_dl;
    logic [SLOT_W-1:0]      r_fired [MAX_RESULTS];
    logic [CNT_W-1:0]       r_nfired;
    logic [FIRE_W-1:0]      r_emit_k;

    logic                   r_any;
    logic [TIME_W-1:0]      r_best;
    logic [TIME_W-1:0]      r_delay;
    logic                   r_arm_valid;

    // output registers
    logic                   r_o_strobe;
    t_kind                  r_o_kind;
    t_status                r_o_status;
    logic [3:0]             r_o_slot;
    logic                   r_o_expired;
    logic                   r_o_arm_valid;
    logic [TIME_W-1:0]      r_o_delay;
    logic                   r_o_last;

    // table and shared unit
    t_tbl_wr                w_wr;
    logic [TIMER_SLOTS-1:0] w_valid;
    logic [TIMER_SLOTS-1:0] w_cancel;
    logic [TIME_W-1:0]      w_rd_dl;
    logic [PERIOD_W-1:0]    w_rd_period;
    t_alu_op                w_op;
    logic [TIME_W-1:0]      w_a;
    logic [TIME_W-1:0]      w_b;
    logic [TIME_W-1:0]      w_res;
    logic                   w_flag;

    logic                   w_accept;
    logic                   w_last_idx;
    logic                   w_cur_valid;
    logic                   w_cur_cancel;
    logic                   w_free_found;
    logic [SLOT_W-1:0]      w_free_idx;
    logic                   w_earliest;
    logic                   w_can_in_range;
    logic [SLOT_W-1:0]      w_can_idx;
    logic                   w_can_ok;
    logic                   w_pick_take;
    logic                   w_pick_found;
    logic [SLOT_W-1:0]      w_pick_idx;
    logic                   w_pick_limit;
    logic                   w_best_take;
    logic                   w_emit_last;

    tdq_table u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (w_wr),
        .i_rd_idx      (r_idx),
        .o_valid       (w_valid),
        .o_cancel      (w_cancel),
        .o_rd_deadline (w_rd_dl),
        .o_rd_period   (w_rd_period)
    );

    tdq_alu u_alu (
        .i_op   (w_op),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_res  (w_res),
        .o_flag (w_flag)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_accept    = start && (r_state == S_IDLE);

    assign w_last_idx   = (r_idx == SLOT_W'(TIMER_SLOTS - 1));
    assign w_cur_valid  = w_valid[r_idx];
    assign w_cur_cancel = w_cancel[r_idx];

    // add scan: lowest free slot, and whether the new deadline beats every valid one
    assign w_free_found = r_free_found || !w_cur_valid;
    assign w_free_idx   = r_free_found ? r_free_idx : r_idx;
    assign w_earliest   = r_earliest && !(w_cur_valid && w_flag);

    assign w_can_in_range = (int'(r_slot) < TIMER_SLOTS);
    assign w_can_idx      = SLOT_W'(r_slot);
    assign w_can_ok       = w_can_in_range && w_valid[w_can_idx];

    // strict less-than keeps the lower slot on equal deadlines
    assign w_pick_take  = r_due[r_idx] && w_cur_valid && !r_handled[r_idx]
                          && (!r_pick_found || w_flag);
    assign w_pick_found = r_pick_found || w_pick_take;
    assign w_pick_idx   = w_pick_take ? r_idx : r_pick_idx;
    assign w_pick_limit = ((r_nfired + CNT_W'(1)) == CNT_W'(MAX_RESULTS));

    assign w_best_take  = w_cur_valid && (!r_any || w_flag);
    assign w_emit_last  = (r_action != ACT_TICK) || (r_nfired == '0)
                          || ((CNT_W'(r_emit_k) + CNT_W'(1)) == r_nfired);

    // operand select for the shared unit
    always_comb begin
        w_op = ALU_GE;
        w_a  = r_now;
        w_b  = w_rd_dl;
        unique case (r_state)
            S_ADD_SCAN: begin
                w_op = ALU_GE;
                w_a  = r_deadline;
                w_b  = w_rd_dl;
            end
            S_CLR: begin
                w_op = ALU_GE;
                w_a  = r_now;
                w_b  = w_rd_dl;
            end
            S_PICK: begin
                w_op = ALU_LT;
                w_a  = w_rd_dl;
                w_b  = r_pick_dl;
            end
            S_UPD: begin
                w_op = ALU_ADD_SAT;
                w_a  = r_now;
                w_b  = TIME_W'(w_rd_period);
            end
            S_BEST: begin
                w_op = ALU_LT;
                w_a  = w_rd_dl;
                w_b  = r_best;
            end
            S_DSUB: begin
                w_op = ALU_SUB_SAT;
                w_a  = (r_action == ACT_ADD) ? r_deadline : r_best;
                w_b  = r_now;
            end
            S_DMIN: begin
                w_op = ALU_LT;
                w_a  = r_delay;
                w_b  = TIME_W'(r_min_delay);
            end
            default: begin
                w_op = ALU_GE;
                w_a  = r_now;
                w_b  = w_rd_dl;
            end
        endcase
    end

    // table writes
    always_comb begin
        w_wr          = '0;
        w_wr.idx      = r_idx;
        w_wr.deadline = w_res;
        w_wr.period   = r_period;
        unique case (r_state)
            S_ADD_SCAN: begin
                if (w_last_idx && w_free_found) begin
                    w_wr.add_en   = 1'b1;
                    w_wr.idx      = w_free_idx;
                    w_wr.deadline = r_deadline;
                end
            end
            S_CAN: begin
                w_wr.cancel_en = w_can_ok;
                w_wr.idx       = w_can_idx;
            end
            S_CLR: begin
                w_wr.free_en = w_cur_valid && w_cur_cancel && w_flag;
            end
            S_UPD: begin
                if (r_handled[r_idx]) begin
                    if (w_rd_period != '0) begin
                        w_wr.dl_en = 1'b1;
                    end else begin
                        w_wr.free_en = 1'b1;
                    end
                end
            end
            default: begin
                w_wr.add_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_action)
                        ACT_ADD:    n_state = S_ADD_SCAN;
                        ACT_CANCEL: n_state = S_CAN;
                        ACT_TICK:   n_state = S_CLR;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_SCAN: begin
                if (w_last_idx) begin
                    n_state = (w_free_found && w_earliest) ? S_DSUB : S_EMIT;
                end
            end
            S_CAN: n_state = S_EMIT;
            S_CLR: begin
                if (w_last_idx) n_state = S_PICK;
            end
            S_PICK: begin
                if (w_last_idx && (!w_pick_found || w_pick_limit)) n_state = S_UPD;
            end
            S_UPD: begin
                if (w_last_idx) n_state = S_BEST;
            end
            S_BEST: begin
                if (w_last_idx) n_state = (r_any || w_cur_valid) ? S_DSUB : S_EMIT;
            end
            S_DSUB: n_state = S_DMIN;
            S_DMIN: n_state = S_EMIT;
            S_EMIT: begin
                if (w_emit_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_min_delay <= MIN_DELAY_RESET;
            r_o_strobe  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_o_strobe <= (r_state == S_EMIT);
            if (i_cfg_valid && o_cfg_ready) begin
                r_min_delay <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_action     <= i_action;
                    r_slot       <= i_slot;
                    r_deadline   <= i_deadline;
                    r_period     <= i_period;
                    r_now        <= i_now;
                    r_idx        <= '0;
                    r_emit_k     <= '0;
                    r_free_found <= 1'b0;
                    r_earliest   <= 1'b1;
                    r_handled    <= '0;
                    r_nfired     <= '0;
                    r_pick_found <= 1'b0;
                    r_arm_valid  <= 1'b0;
                end
            end
            S_ADD_SCAN: begin
                r_free_found <= w_free_found;
                r_free_idx   <= w_free_idx;
                r_earliest   <= w_earliest;
                r_idx        <= w_last_idx ? '0 : r_idx + SLOT_W'(1);
                if (w_last_idx) begin
                    r_status    <= w_free_found ? ST_OK : ST_FULL;
                    r_arm_valid <= w_free_found && w_earliest;
                end
            end
            S_CAN: begin
                r_status <= w_can_ok ? ST_OK : ST_BAD_SLOT;
            end
            S_CLR: begin
                r_due[r_idx] <= w_flag;
                r_idx        <= w_last_idx ? '0 : r_idx + SLOT_W'(1);
            end
            S_PICK: begin
                r_pick_found <= w_last_idx ? 1'b0 : w_pick_found;
                r_pick_idx   <= w_pick_idx;
                if (w_pick_take) r_pick_dl <= w_rd_dl;
                r_idx <= w_last_idx ? '0 : r_idx + SLOT_W'(1);
                if (w_last_idx && w_pick_found) begin
                    r_handled[w_pick_idx]         <= 1'b1;
                    r_fired[r_nfired[FIRE_W-1:0]] <= w_pick_idx;
                    r_nfired                      <= r_nfired + CNT_W'(1);
                end
            end
            S_UPD: begin
                r_idx <= w_last_idx ? '0 : r_idx + SLOT_W'(1);
                r_any <= 1'b0;
            end
            S_BEST: begin
                if (w_best_take) begin
                    r_best <= w_rd_dl;
                    r_any  <= 1'b1;
                end
                r_idx <= w_last_idx ? '0 : r_idx + SLOT_W'(1);
                if (w_last_idx) begin
                    r_arm_valid <= r_any || w_cur_valid;
                end
            end
            S_DSUB: begin
                r_delay <= w_res;
            end
            S_DMIN: begin
                if (w_flag) r_delay <= TIME_W'(r_min_delay);
            end
            S_EMIT: begin
                r_emit_k      <= r_emit_k + FIRE_W'(1);
                r_o_arm_valid <= r_arm_valid;
                r_o_delay     <= r_arm_valid ? r_delay : '0;
                r_o_last      <= w_emit_last;
                case (r_action)
                    ACT_ADD: begin
                        r_o_kind    <= KIND_ADD;
                        r_o_status  <= r_status;
                        r_o_expired <= 1'b0;
                        r_o_slot    <= (r_status == ST_OK) ? 4'(r_free_idx) : 4'd0;
                    end
                    ACT_CANCEL: begin
                        r_o_kind    <= KIND_CANCEL;
                        r_o_status  <= r_status;
                        r_o_expired <= 1'b0;
                        r_o_slot    <= r_slot;
                    end
                    default: begin
                        r_o_kind    <= KIND_TICK;
                        r_o_status  <= ST_OK;
                        r_o_expired <= (r_nfired != '0);
                        r_o_slot    <= (r_nfired != '0) ? 4'(r_fired[r_emit_k]) : 4'd0;
                    end
                endcase
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    assign o_result_strobe = r_o_strobe;
    assign o_kind          = r_o_kind;
    assign o_status        = r_o_status;
    assign o_result_slot   = r_o_slot;
    assign o_expired       = r_o_expired;
    assign o_arm_valid     = r_o_arm_valid;
    assign o_arm_delay     = r_o_delay;
    assign o_last          = r_o_last;

endmodule

// ----- sv/tdq_alu.sv -----
`timescale 1ns / 1ps

// Shared 64-bit add/subtract unit: compares, saturating difference and
// saturating sum all run through the one carry chain.
module tdq_alu import tdq_pkg::*; (
    input  t_alu_op           i_op,
    input  logic [TIME_W-1:0] i_a,
    input  logic [TIME_W-1:0] i_b,
    output logic [TIME_W-1:0] o_res,
    output logic              o_flag
);

    logic            w_sub;
    logic [TIME_W:0] w_sum;
    logic            w_carry;

    assign w_sub   = (i_op != ALU_ADD_SAT);
    assign w_sum   = {1'b0, i_a} + {1'b0, (w_sub ? ~i_b : i_b)} + {{TIME_W{1'b0}}, w_sub};
    // on subtract, carry out set means a >= b
    assign w_carry = w_sum[TIME_W];

    always_comb begin
        o_res  = '0;
        o_flag = 1'b0;
        case (i_op)
            ALU_GE: begin
                o_flag = w_carry;
            end
            ALU_LT: begin
                o_flag = ~w_carry;
            end
            ALU_SUB_SAT: begin
                o_flag = w_carry;
                o_res  = w_carry ? w_sum[TIME_W-1:0] : '0;
            end
            ALU_ADD_SAT: begin
                o_flag = w_carry;
                o_res  = w_carry ? '1 : w_sum[TIME_W-1:0];
            end
            default: begin
                o_res  = '0;
                o_flag = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/tdq_table.sv -----
`timescale 1ns / 1ps

// Timer slot storage: valid and cancel bits in flops, deadline and period
// per slot, one read index.
module tdq_table import tdq_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_tbl_wr                i_wr,
    input  logic [SLOT_W-1:0]      i_rd_idx,
    output logic [TIMER_SLOTS-1:0] o_valid,
    output logic [TIMER_SLOTS-1:0] o_cancel,
    output logic [TIME_W-1:0]      o_rd_deadline,
    output logic [PERIOD_W-1:0]    o_rd_period
);

    logic [TIMER_SLOTS-1:0] r_valid;
    logic [TIMER_SLOTS-1:0] r_cancel;
    logic [TIME_W-1:0]      r_deadline [TIMER_SLOTS];
    logic [PERIOD_W-1:0]    r_period   [TIMER_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_cancel <= '0;
        end else begin
            if (i_wr.add_en) begin
                r_valid[i_wr.idx]  <= 1'b1;
                r_cancel[i_wr.idx] <= 1'b0;
            end
            if (i_wr.cancel_en) begin
                r_cancel[i_wr.idx] <= 1'b1;
            end
            if (i_wr.free_en) begin
                r_valid[i_wr.idx]  <= 1'b0;
                r_cancel[i_wr.idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.add_en) begin
            r_deadline[i_wr.idx] <= i_wr.deadline;
            r_period[i_wr.idx]   <= i_wr.period;
        end
        if (i_wr.dl_en) begin
            r_deadline[i_wr.idx] <= i_wr.deadline;
        end
    end

    assign o_valid       = r_valid;
    assign o_cancel      = r_cancel;
    assign o_rd_deadline = r_deadline[i_rd_idx];
    assign o_rd_period   = r_period[i_rd_idx];

endmodule

// ----- sv/tdq_mon.sv -----
`timescale 1ns / 1ps

`include "timer_deadline_queue_unit_assert.svh"

module tdq_mon import tdq_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic [1:0]        i_action,
    input logic              o_result_strobe,
    input logic [1:0]        o_kind,
    input logic              o_expired,
    input logic              o_arm_valid,
    input logic [TIME_W-1:0] o_arm_delay,
    input logic              o_last
);

    logic w_side_result;
    logic w_known_start;
    logic w_disarmed;

    assign w_side_result = o_result_strobe && (o_kind != KIND_TICK);
    assign w_known_start = start && !busy && (i_action <= ACT_TICK);
    assign w_disarmed    = o_result_strobe && !o_arm_valid;

    // a tick burst runs on consecutive cycles until its final result
    `TDQ_ASSERT(a_burst_contiguous, o_result_strobe && !o_last |=> o_result_strobe, "burst gap")

    // add and cancel each give one result
    `TDQ_ASSERT(a_single_result, w_side_result |-> o_last && !o_expired, "add/cancel not single")

    // an accepted command with a known action keeps the block busy
    `TDQ_ASSERT(a_busy_after_start, w_known_start |=> busy, "block not busy after command")

    `TDQ_ASSERT(a_no_arm_zero_delay, w_disarmed |-> (o_arm_delay == '0), "delay without arm")

endmodule

bind timer_deadline_queue_unit tdq_mon u_tdq_mon (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_action        (i_action),
    .o_result_strobe (o_result_strobe),
    .o_kind          (o_kind),
    .o_expired       (o_expired),
    .o_arm_valid     (o_arm_valid),
    .o_arm_delay     (o_arm_delay),
    .o_last          (o_last)
);
